// File: rtl/minv_pkg.sv
// ---------------------------------------------------------------------------
// minv_pkg: shared types and tables for the 4x4 matrix inverse
// Phase codes, the 2x2 minor and cofactor index tables, and the command and
// status words that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package minv_pkg;

  typedef logic [3:0] idx_t;

  localparam idx_t LAST_POS = 4'd15;

  // Work phases of the multiply-accumulate sequence
  typedef enum logic [1:0] {
    PH_MINOR = 2'd0,
    PH_COF   = 2'd1,
    PH_DET   = 2'd2
  } phase_t;

  // Minor k = a[t0]*a[t1] - a[t2]*a[t3]
  localparam int MINOR_TAB [12][4] = '{
    '{0, 5, 1, 4}, '{0, 6, 2, 4}, '{0, 7, 3, 4}, '{1, 6, 2, 5},
    '{1, 7, 3, 5}, '{2, 7, 3, 6}, '{8, 13, 9, 12}, '{8, 14, 10, 12},
    '{8, 15, 11, 12}, '{9, 14, 10, 13}, '{9, 15, 11, 13}, '{10, 15, 11, 14}
  };

  // Cofactor k = s*(a[e0]*b[b0] - a[e1]*b[b1] + a[e2]*b[b2]), s from last column
  localparam int COF_TAB [16][7] = '{
    '{5, 11, 6, 10, 7, 9, 0},  '{1, 11, 2, 10, 3, 9, 1},
    '{13, 5, 14, 4, 15, 3, 0}, '{9, 5, 10, 4, 11, 3, 1},
    '{4, 11, 6, 8, 7, 7, 1},   '{0, 11, 2, 8, 3, 7, 0},
    '{12, 5, 14, 2, 15, 1, 1}, '{8, 5, 10, 2, 11, 1, 0},
    '{4, 10, 5, 8, 7, 6, 0},   '{0, 10, 1, 8, 3, 6, 1},
    '{12, 4, 13, 2, 15, 0, 0}, '{8, 4, 9, 2, 11, 0, 1},
    '{4, 9, 5, 7, 6, 6, 1},    '{0, 9, 1, 7, 2, 6, 0},
    '{12, 3, 13, 1, 14, 0, 1}, '{8, 3, 9, 1, 10, 0, 0}
  };

  typedef struct packed {
    logic       wr_elem;
    idx_t       elem_idx;
    logic       mac_issue;
    phase_t     ph;
    idx_t       item;
    logic [1:0] sub;
    logic [1:0] chunk;
    logic       div_init;
    logic       div_step;
    idx_t       pos;
    logic       out_load;
    logic       out_singular;
    logic       out_last;
  } minv_cmd_t;

  typedef struct packed {
    logic det_zero;
  } minv_stat_t;

endpackage

`default_nettype wire

// File: rtl/minv_dp.sv
// ---------------------------------------------------------------------------
// minv_dp: datapath of the 4x4 matrix inverse
// Element store, one shared chunked multiply-accumulate unit for minors,
// cofactors and determinant, a restoring divider and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module minv_dp import minv_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int ELEMENT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire minv_cmd_t   cmd,
  input  wire logic [31:0] matrix_element,
  output minv_stat_t       stat,
  output logic      [31:0] inverse_element,
  output logic      [3:0]  element_position,
  output logic             singular,
  output logic             saturated,
  output logic             last_result
);

  localparam int E  = ELEMENT_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int WW = 4 * E;          // wide operand, four chunks
  localparam int PW = 5 * E;          // product and accumulator
  localparam int MW = 2 * E + 1;      // 2x2 minor
  localparam int NW = WW + 2 * F;     // scaled dividend
  localparam int QB = E + 1;          // quotient bits kept
  localparam int RW = NW + 1;         // remainder
  localparam logic [QB-1:0] LIM = QB'(1) << (E - 1);
  localparam logic signed [E-1:0] MAXV = {1'b0, {(E - 1){1'b1}}};
  localparam logic signed [E-1:0] MINV = {1'b1, {(E - 1){1'b0}}};

  // Stores
  logic signed [E-1:0]  elem_a [16];
  logic signed [E-1:0]  elem_w [16];
  logic signed [MW-1:0] mn     [12];
  logic signed [WW-1:0] cofs   [16];
  logic signed [PW-1:0] det;

  // MAC pipeline
  logic signed [E-1:0]  a_op;
  logic signed [WW-1:0] wop;
  logic [E-1:0]         chk;
  logic signed [E:0]    opc;
  logic                 t_neg;
  logic                 t_first;
  logic                 t_last;
  logic signed [MW-1:0] prod;
  logic                 s1_valid;
  logic                 s1_first_chunk;
  logic                 s1_last_chunk;
  logic                 s1_first;
  logic                 s1_last;
  logic                 s1_neg;
  phase_t               s1_ph;
  idx_t                 s1_item;
  logic signed [PW-1:0] p;
  logic                 s2_valid;
  logic                 s2_first;
  logic                 s2_last;
  logic                 s2_neg;
  phase_t               s2_ph;
  idx_t                 s2_item;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] acc_next;

  // Divider
  logic [PW-1:0]        dabs;
  logic [RW-1:0]        dmag;
  logic                 det_neg;
  logic signed [WW-1:0] cval;
  logic [WW-1:0]        cmag;
  logic [NW-1:0]        num;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        rem2;
  logic [QB-1:0]        nlow;
  logic [QB-1:0]        quo;
  logic                 big;
  logic                 qneg;
  logic                 ovf;
  logic signed [E-1:0]  res;

  // Load elements into both copies of the store
  always_ff @(posedge clk) begin
    if (cmd.wr_elem) begin
      elem_a[cmd.elem_idx] <= matrix_element[E-1:0];
      elem_w[cmd.elem_idx] <= matrix_element[E-1:0];
    end
  end

  // Decode the current term of the sequence
  always_comb begin
    a_op    = '0;
    wop     = '0;
    t_neg   = 1'b0;
    t_first = 1'b0;
    t_last  = 1'b0;
    case (cmd.ph)
      PH_MINOR: begin
        a_op    = elem_a[4'(MINOR_TAB[cmd.item][2 * cmd.sub])];
        wop     = WW'(elem_w[4'(MINOR_TAB[cmd.item][2 * cmd.sub + 1])]);
        t_neg   = cmd.sub[0];
        t_first = (cmd.sub == 2'd0);
        t_last  = (cmd.sub == 2'd1);
      end
      PH_COF: begin
        a_op    = elem_a[4'(COF_TAB[cmd.item][2 * cmd.sub])];
        wop     = WW'(mn[4'(COF_TAB[cmd.item][2 * cmd.sub + 1])]);
        t_neg   = cmd.sub[0] ^ (COF_TAB[cmd.item][6] != 0);
        t_first = (cmd.sub == 2'd0);
        t_last  = (cmd.sub == 2'd2);
      end
      PH_DET: begin
        a_op    = elem_a[{2'b00, cmd.sub}];
        wop     = cofs[{cmd.sub, 2'b00}];
        t_first = (cmd.sub == 2'd0);
        t_last  = (cmd.sub == 2'd3);
      end
      default: begin
        a_op = '0;
      end
    endcase
    chk = wop[cmd.chunk * E +: E];
    opc = (cmd.chunk == 2'd3) ? {chk[E-1], chk} : {1'b0, chk};
  end

  // Multiply one chunk, then fold chunks top down, then accumulate terms
  always_ff @(posedge clk) begin
    prod           <= a_op * opc;
    s1_first_chunk <= (cmd.chunk == 2'd3);
    s1_last_chunk  <= (cmd.chunk == 2'd0);
    s1_first       <= t_first;
    s1_last        <= t_last;
    s1_neg         <= t_neg;
    s1_ph          <= cmd.ph;
    s1_item        <= cmd.item;
    if (s1_first_chunk) begin
      p <= PW'(prod);
    end else begin
      p <= (p <<< E) + PW'(prod);
    end
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_neg   <= s1_neg;
    s2_ph    <= s1_ph;
    s2_item  <= s1_item;
  end

  always_comb begin
    acc_next = (s2_first ? '0 : acc) + (s2_neg ? -p : p);
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
      if (s2_last) begin
        case (s2_ph)
          PH_MINOR: mn[s2_item]   <= acc_next[MW-1:0];
          PH_COF:   cofs[s2_item] <= acc_next[WW-1:0];
          PH_DET:   det           <= acc_next;
          default:  acc           <= acc_next;
        endcase
      end
    end
  end

  // Pipeline valid bits: only the final chunk of a term reaches the adder
  always_ff @(posedge clk) begin
    s1_valid <= cmd.mac_issue;
    s2_valid <= s1_valid && s1_last_chunk;
  end

  assign stat.det_zero = (det == '0);

  // Divisor magnitude follows the determinant
  assign dabs = det[PW-1] ? PW'(-det) : PW'(det);
  always_ff @(posedge clk) begin
    dmag    <= RW'(dabs);
    det_neg <= det[PW-1];
  end

  // Restoring division, one quotient bit per step
  always_comb begin
    cval = cofs[cmd.pos];
    cmag = cval[WW-1] ? WW'(-cval) : WW'(cval);
    num  = {cmag, {(2 * F){1'b0}}};
    rem2 = {rem[RW-2:0], nlow[QB-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= RW'(num[NW-1:QB]);
      big  <= (RW'(num[NW-1:QB]) >= dmag);
      nlow <= num[QB-1:0];
      quo  <= '0;
      qneg <= cval[WW-1] ^ det_neg;
    end else if (cmd.div_step) begin
      if (rem2 >= dmag) begin
        rem <= rem2 - dmag;
      end else begin
        rem <= rem2;
      end
      quo  <= {quo[QB-2:0], (rem2 >= dmag)};
      nlow <= nlow << 1;
    end
  end

  // Saturate and sign the quotient
  always_comb begin
    ovf = big || (qneg ? (quo > LIM) : (quo >= LIM));
    if (ovf) begin
      res = qneg ? MINV : MAXV;
    end else begin
      res = qneg ? -E'(quo) : E'(quo);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_singular) begin
        inverse_element  <= '0;
        element_position <= '0;
        saturated        <= 1'b0;
      end else begin
        inverse_element  <= 32'(res);
        element_position <= cmd.pos;
        saturated        <= ovf;
      end
      singular    <= cmd.out_singular;
      last_result <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/minv_ctrl.sv
// ---------------------------------------------------------------------------
// minv_ctrl: sequencer of the 4x4 matrix inverse
// Counts loads, steps the multiply-accumulate terms chunk by chunk, runs the
// divider per element and owns the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module minv_ctrl import minv_pkg::*; #(
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       out_stall,
  output logic            out_valid,
  input  wire minv_stat_t stat,
  output minv_cmd_t       cmd
);

  localparam int QB = ELEMENT_BITS + 1;
  localparam int SW = $clog2(QB + 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(QB - 1);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_MAC     = 8'b0000_0010,
    S_DRAIN   = 8'b0000_0100,
    S_CHECK   = 8'b0000_1000,
    S_SING    = 8'b0001_0000,
    S_DIVINIT = 8'b0010_0000,
    S_DIV     = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t        state;
  state_t        state_next;
  idx_t          load_cnt;
  phase_t        ph;
  idx_t          item;
  logic [1:0]    sub;
  logic [1:0]    chunk;
  logic [1:0]    drain;
  logic [SW-1:0] step;
  idx_t          k;
  logic          slot_free;
  logic          in_acc;
  logic [1:0]    sub_last;
  idx_t          item_last;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;

  // Term and item limits of each phase
  always_comb begin
    case (ph)
      PH_MINOR: begin
        sub_last  = 2'd1;
        item_last = 4'd11;
      end
      PH_COF: begin
        sub_last  = 2'd2;
        item_last = 4'd15;
      end
      default: begin
        sub_last  = 2'd3;
        item_last = 4'd0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:    if (in_acc && load_cnt == LAST_POS) state_next = S_MAC;
      S_MAC: begin
        if (chunk == 2'd0 && sub == sub_last && item == item_last && ph != PH_COF) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain == 2'd0) state_next = (ph == PH_DET) ? S_CHECK : S_MAC;
      end
      S_CHECK:   state_next = stat.det_zero ? S_SING : S_DIVINIT;
      S_SING:    if (slot_free) state_next = S_LOAD;
      S_DIVINIT: state_next = S_DIV;
      S_DIV:     if (step == STEP_LAST) state_next = S_OUT;
      S_OUT: begin
        if (slot_free) state_next = (k == LAST_POS) ? S_LOAD : S_DIVINIT;
      end
      default:   state_next = S_LOAD;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      load_cnt <= '0;
      ph       <= PH_MINOR;
      item     <= '0;
      sub      <= '0;
      chunk    <= 2'd3;
      drain    <= '0;
      step     <= '0;
      k        <= '0;
    end else begin
      state <= state_next;
      if (in_acc) load_cnt <= load_cnt + 4'd1;
      if (state == S_LOAD) begin
        ph    <= PH_MINOR;
        item  <= '0;
        sub   <= '0;
        chunk <= 2'd3;
        k     <= '0;
      end
      // Advance chunk, term, item and phase
      if (state == S_MAC) begin
        chunk <= chunk - 2'd1;
        if (chunk == 2'd0) begin
          if (sub == sub_last) begin
            sub <= '0;
            if (item == item_last) begin
              item  <= '0;
              drain <= 2'd2;
              if (ph == PH_MINOR) ph <= PH_COF;
              else if (ph == PH_COF) ph <= PH_DET;
            end else begin
              item <= item + 4'd1;
            end
          end else begin
            sub <= sub + 2'd1;
          end
        end
      end
      if (state == S_DRAIN) drain <= drain - 2'd1;
      if (state == S_DIVINIT) step <= '0;
      if (state == S_DIV) step <= step + SW'(1);
      if (state == S_OUT && slot_free) k <= k + 4'd1;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd              = '0;
    cmd.wr_elem      = in_acc;
    cmd.elem_idx     = load_cnt;
    cmd.mac_issue    = (state == S_MAC);
    cmd.ph           = ph;
    cmd.item         = item;
    cmd.sub          = sub;
    cmd.chunk        = chunk;
    cmd.div_init     = (state == S_DIVINIT);
    cmd.div_step     = (state == S_DIV);
    cmd.pos          = k;
    cmd.out_load     = (state == S_OUT || state == S_SING) && slot_free;
    cmd.out_singular = (state == S_SING);
    cmd.out_last     = (state == S_SING) || (k == LAST_POS);
  end

`ifndef NO_ASSERTIONS
  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output word loaded over an unaccepted word");
  a_start_mac: assert property (@(posedge clk) disable iff (rst)
    (in_acc && load_cnt == LAST_POS) |=> (state == S_MAC && ph == PH_MINOR))
    else $error("sixteenth element did not start the sequence");
  a_check_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_DRAIN && ph == PH_DET))
    else $error("determinant checked before the pipeline drained");
  a_det_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && ph == PH_DET) |-> (item == 4'd0))
    else $error("determinant phase stepped past its single item");
`endif

endmodule

`default_nettype wire

// File: rtl/matrix4x4_inverse_top.sv
// ---------------------------------------------------------------------------
// matrix4x4_inverse_top: 4x4 fixed-point matrix inverse, cofactor method
// Takes 16 elements column-major; returns 16 inverse elements or one
// singular word. Exact minors, cofactors and determinant, then division.
// ---------------------------------------------------------------------------
// Sequence: 16 loads, then 76 multiply-accumulate terms of 4 chunks each
//   plus pipeline drain to the determinant, then one pass of the one
//   restoring divider per inverse element.
// No new matrix is taken until the last result word of the previous one is
//   loaded; speed is set by the shared chunked multiplier and the divider.
// Reset clears the controller and counters; the element store is not cleared.
`default_nettype none

module matrix4x4_inverse_top import minv_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int ELEMENT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] matrix_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] inverse_element,
  output logic      [3:0]  element_position,
  output logic             singular,
  output logic             saturated,
  output logic             last_result
);

  minv_cmd_t  cmd;
  minv_stat_t stat;

  minv_ctrl #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  minv_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .ELEMENT_BITS  (ELEMENT_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .matrix_element   (matrix_element),
    .stat             (stat),
    .inverse_element  (inverse_element),
    .element_position (element_position),
    .singular         (singular),
    .saturated        (saturated),
    .last_result      (last_result)
  );

endmodule

`default_nettype wire

// File: tb/tb_matrix4x4_inverse_top.sv
// ---------------------------------------------------------------------------
// tb_matrix4x4_inverse_top: self-checking bench for the 4x4 matrix inverse
// Loads whole matrices word by word, predicts the inverse with exact wide
// integer arithmetic, and compares every result word field by field while
// both sides idle and stall at random in several phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix4x4_inverse_top;
  import minv_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int WATCH_LIMIT = 40000;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  pos;
    logic        sing;
    logic        sat;
    logic        last;
  } inv_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] matrix_element;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] inverse_element;
  logic [3:0]  element_position;
  logic        singular;
  logic        saturated;
  logic        last_result;

  inv_word_t   inverse_q[$];
  logic [31:0] load_buf[16];
  int          load_idx;
  int          sender_idle_pct;
  int          stall_pct;
  int          hold_len;
  int          err_count;
  int          words_in;
  int          words_out;
  int          singular_seen;
  int          sat_seen;
  int          quiet_cycles;

  matrix4x4_inverse_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .matrix_element   (matrix_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .inverse_element  (inverse_element),
    .element_position (element_position),
    .singular         (singular),
    .saturated        (saturated),
    .last_result      (last_result)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Expand a stored word to a signed wide value
  function automatic wide_t widen(logic [31:0] w);
    return wide_t'($signed(w));
  endfunction

  // Compute the inverse words of one loaded matrix and queue them
  task automatic predict_inverse(input logic [31:0] m[16]);
    wide_t     a[16];
    wide_t     b[12];
    wide_t     det, dmag, cof, num, quo;
    wide_t     lim;
    logic      neg;
    inv_word_t w;
    for (int k = 0; k < 16; k++) a[k] = widen(m[k]);
    for (int k = 0; k < 12; k++)
      b[k] = a[MINOR_TAB[k][0]] * a[MINOR_TAB[k][1]]
           - a[MINOR_TAB[k][2]] * a[MINOR_TAB[k][3]];
    det = b[0] * b[11] - b[1] * b[10] + b[2] * b[9]
        + b[3] * b[8] - b[4] * b[7] + b[5] * b[6];
    if (det == 0) begin
      w = '{value: '0, pos: '0, sing: 1'b1, sat: 1'b0, last: 1'b1};
      inverse_q.push_back(w);
      return;
    end
    dmag = (det < 0) ? -det : det;
    lim  = wide_t'(1) <<< 31;
    for (int k = 0; k < 16; k++) begin
      cof = a[COF_TAB[k][0]] * b[COF_TAB[k][1]]
          - a[COF_TAB[k][2]] * b[COF_TAB[k][3]]
          + a[COF_TAB[k][4]] * b[COF_TAB[k][5]];
      if (COF_TAB[k][6] != 0) cof = -cof;
      neg = (cof < 0) != (det < 0);
      num = ((cof < 0) ? -cof : cof) <<< (2 * FRAC_BITS);
      quo = num / dmag;
      w.pos  = 4'(k);
      w.sing = 1'b0;
      w.last = (4'(k) == LAST_POS);
      if (neg) begin
        w.sat   = (quo > lim);
        w.value = w.sat ? 32'h8000_0000 : 32'(-quo);
      end else begin
        w.sat   = (quo > lim - 1);
        w.value = w.sat ? 32'h7fff_ffff : 32'(quo);
      end
      inverse_q.push_back(w);
    end
  endtask

  // Offer one word, idling first at random, and wait for its acceptance
  task automatic send_word(input logic [31:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    matrix_element <= v;
    do @(posedge clk); while (in_stall);
    words_in++;
    load_buf[load_idx] = v;
    if (load_idx == 15) begin
      predict_inverse(load_buf);
      load_idx = 0;
    end else begin
      load_idx++;
    end
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic drain;
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_matrix(input logic [31:0] m[16]);
    for (int k = 0; k < 16; k++) send_word(m[k]);
  endtask

  // Build a random matrix: full range, small fixed point, or singular
  task automatic random_matrix(output logic [31:0] m[16]);
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 16; k++) begin
      if (mode < 4) m[k] = $urandom();
      else m[k] = 32'(($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS)
                  + 32'($urandom_range(0, 3) <<< 14);
    end
    // Copy a column to force a zero determinant
    if (mode >= 8) for (int r = 0; r < 4; r++) m[8 + r] = m[r];
  endtask

  task automatic test_directed;
    logic [31:0] m[16];
    sender_idle_pct = 0;
    stall_pct       = 0;
    // Identity matrix
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
    send_matrix(m);
    // Tiny diagonal of mixed sign overflows both ways
    for (int k = 0; k < 16; k++) m[k] = 32'h0;
    m[0] = 32'h1; m[5] = 32'hffff_ffff; m[10] = 32'h1; m[15] = 32'h1;
    send_matrix(m);
    // Extreme diagonal gives tiny inverse elements
    for (int k = 0; k < 16; k++) m[k] = 32'h0;
    m[0] = 32'h7fff_ffff; m[5] = 32'h8000_0000; m[10] = 32'h7fff_ffff;
    m[15] = 32'h8000_0000;
    send_matrix(m);
    // All-zero matrix is singular
    for (int k = 0; k < 16; k++) m[k] = 32'h0;
    send_matrix(m);
    drain();
  endtask

  task automatic test_random(input int n_mat, input int idle_pct, input int stl_pct);
    logic [31:0] m[16];
    sender_idle_pct = idle_pct;
    stall_pct       = stl_pct;
    for (int i = 0; i < n_mat; i++) begin
      random_matrix(m);
      send_matrix(m);
    end
    drain();
  endtask

  // Hold the receiver off while matrices keep coming, then stall it at random
  task automatic test_backpressure;
    logic [31:0] m[16];
    sender_idle_pct = 0;
    stall_pct       = 20;
    hold_len        = 3000;
    for (int i = 0; i < 3; i++) begin
      random_matrix(m);
      send_matrix(m);
    end
    drain();
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    matrix_element  = '0;
    load_idx        = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_len        = 0;
    err_count       = 0;
    words_in        = 0;
    words_out       = 0;
    singular_seen   = 0;
    sat_seen        = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(6, 0, 0);
    test_random(6, 75, 0);
    test_random(5, 0, 75);
    test_random(5, 31, 31);
    test_backpressure();
    $display("Run covered %0d matrix words in, %0d inverse words out", words_in, words_out);
    $display("  with %0d singular and %0d saturated words", singular_seen, sat_seen);
    if (err_count == 0) $display("PASS matrix4x4_inverse_top");
    else $display("FAIL matrix4x4_inverse_top");
    $finish;
  end

  // Drive the receiver stall: long hold-off first, else random
  initial begin
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len  = hold_len - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (inverse_q.size() == 0) begin
        $error("unexpected word: inverse_element %h", inverse_element);
        err_count++;
      end else begin
        inv_word_t e;
        e = inverse_q.pop_front();
        if (inverse_element !== e.value) begin
          $error("inverse_element: expected %h actual %h", e.value, inverse_element);
          err_count++;
        end
        if (element_position !== e.pos) begin
          $error("element_position: expected %0d actual %0d", e.pos, element_position);
          err_count++;
        end
        if (singular !== e.sing) begin
          $error("singular: expected %b actual %b", e.sing, singular);
          err_count++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %b actual %b", e.sat, saturated);
          err_count++;
        end
        if (last_result !== e.last) begin
          $error("last_result: expected %b actual %b", e.last, last_result);
          err_count++;
        end
        if (e.sing) singular_seen++;
        if (e.sat) sat_seen++;
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("FAIL matrix4x4_inverse_top");
        $finish;
      end
    end
  end

endmodule
